### rtl/core/field_discard_line_average_deinterlace_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the deinterlacer core.
// ---------------------------------------------------------------------------
`ifndef FIELD_DISCARD_LINE_AVERAGE_DEINTERLACE_CORE_MACROS_SVH
`define FIELD_DISCARD_LINE_AVERAGE_DEINTERLACE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDLAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDLAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fdlad_pkg.sv
// ---------------------------------------------------------------------------
// fdlad_pkg
// Types and fixed constants of the line-average deinterlacer core.
// ---------------------------------------------------------------------------
package fdlad_pkg;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int POS_W     = 12;
  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT = 1'b1;

  // Register limits and reset values.
  localparam int WIDTH_MIN        = 2;
  localparam int LINES_MIN        = 4;
  localparam int RESET_LINE_WIDTH = 720;
  localparam int RESET_LINE_COUNT = 480;

  // What one accepted sample produces.
  typedef struct packed {
    logic emit;      // at least one result
    logic has_up;    // a rebuilt line above is produced first
    logic up_copy;   // that line copies the sample instead of averaging
    logic has_down;  // the bottom edge line is copied after the sample
    logic wr;        // the sample goes into the line store
  } plan_t;

  // Which result of a run is being offered.
  typedef enum logic [1:0] {
    SLOT_UP,
    SLOT_SELF,
    SLOT_DOWN
  } slot_t;

endpackage

### rtl/core/fdlad_if.sv
// ---------------------------------------------------------------------------
// fdlad_in_if / fdlad_out_if
// Valid/ready channels for incoming samples and produced results.
// ---------------------------------------------------------------------------
interface fdlad_in_if;
  import fdlad_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             top_field_first;

  modport source (output valid, output pixel, output top_field_first, input ready);
  modport sink (input valid, input pixel, input top_field_first, output ready);
endinterface

interface fdlad_out_if;
  import fdlad_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] column;
  logic [PIX_W-1:0] value;
  logic             last_of_run;

  modport source (output valid, output row, output column, output value,
                  output last_of_run, input ready);
  modport sink (input valid, input row, input column, input value,
                input last_of_run, output ready);
endinterface

### rtl/core/fdlad_ram.sv
// ---------------------------------------------------------------------------
// fdlad_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module fdlad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/fdlad_front.sv
// ---------------------------------------------------------------------------
// fdlad_front
// Configuration registers, raster counters, per-sample decision and the
// stage that waits for the line store read.
// ---------------------------------------------------------------------------
module fdlad_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_LINES = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   write_en,
  input  logic [fdlad_pkg::REG_IDX_W-1:0]        reg_index,
  input  logic [fdlad_pkg::CFG_W-1:0]            write_data,
  fdlad_in_if.sink                               sample,
  input  logic                                   s1_take,
  output logic                                   s1_valid,
  output fdlad_pkg::plan_t                       s1_plan,
  output logic [$clog2(MAX_LINES)-1:0]           s1_row,
  output logic [$clog2(MAX_WIDTH)-1:0]           s1_col,
  output logic [fdlad_pkg::PIX_W-1:0]            s1_pix,
  output logic                                   rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]           rd_addr
);
  import fdlad_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_LINES);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(MAX_LINES + 1);
  localparam int RST_WIDTH = (RESET_LINE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_LINE_WIDTH;
  localparam int RST_LINES = (RESET_LINE_COUNT > MAX_LINES) ? MAX_LINES : RESET_LINE_COUNT;

  logic [WW-1:0] line_width;
  logic [LW-1:0] line_lines;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          keep_top;

  logic          accept;
  logic          first;
  logic          keep_top_eff;
  logic [LW-1:0] even_lines;
  logic          pass;
  logic          keep;
  logic [LW:0]   row_plus2;
  logic [WW-1:0] col_inc;
  logic [LW-1:0] row_inc;
  plan_t         plan;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = !s1_valid || s1_take;

  // Registers are stored already clamped to their legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WW'(RST_WIDTH);
      line_lines <= LW'(RST_LINES);
    end else if (write_en) begin
      unique case (reg_index)
        REG_LINE_WIDTH: begin
          if (int'(write_data) < WIDTH_MIN) begin
            line_width <= WW'(WIDTH_MIN);
          end else if (int'(write_data) > MAX_WIDTH) begin
            line_width <= WW'(MAX_WIDTH);
          end else begin
            line_width <= WW'(write_data);
          end
        end
        REG_LINE_COUNT: begin
          if (int'(write_data) < LINES_MIN) begin
            line_lines <= LW'(LINES_MIN);
          end else if (int'(write_data) > MAX_LINES) begin
            line_lines <= LW'(MAX_LINES);
          end else begin
            line_lines <= LW'(write_data);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Decide what this sample produces.
  always_comb begin
    first        = (row == '0) && (col == '0);
    keep_top_eff = first ? sample.top_field_first : keep_top;
    even_lines   = {line_lines[LW-1:1], 1'b0};
    pass         = LW'(row) >= even_lines;
    keep         = keep_top_eff ? !row[0] : row[0];
    row_plus2    = (LW + 1)'(row) + (LW + 1)'(2);

    plan.emit     = pass || keep;
    plan.wr       = !pass && keep;
    plan.has_up   = !pass && keep && (!keep_top_eff || (row >= RW'(2)));
    plan.up_copy  = !keep_top_eff && (row == RW'(1));
    plan.has_down = !pass && keep && keep_top_eff && (row_plus2 == {1'b0, even_lines});
  end

  // Raster position and the latched field order.
  assign col_inc = WW'(col) + WW'(1);
  assign row_inc = LW'(row) + LW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      keep_top <= 1'b1;
    end else if (accept) begin
      keep_top <= keep_top_eff;
      if (col_inc >= line_width) begin
        col <= '0;
        row <= (row_inc >= line_lines) ? '0 : RW'(row_inc);
      end else begin
        col <= CW'(col_inc);
      end
    end
  end

  // Stage holding a sample while its line store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_plan <= plan;
      s1_row  <= row;
      s1_col  <= col;
      s1_pix  <= sample.pixel;
    end
  end

  assign rd_en   = accept;
  assign rd_addr = col;

endmodule

### rtl/core/fdlad_emit.sv
// ---------------------------------------------------------------------------
// fdlad_emit
// Result register: forms the average and offers the results of one sample,
// one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module fdlad_emit #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_LINES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s1_valid,
  input  fdlad_pkg::plan_t             s1_plan,
  input  logic [$clog2(MAX_LINES)-1:0] s1_row,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_col,
  input  logic [fdlad_pkg::PIX_W-1:0]  s1_pix,
  input  logic [fdlad_pkg::PIX_W-1:0]  rd_data,
  fdlad_out_if.source                  result,
  output logic                         free
);
  import fdlad_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_LINES);

  logic             s2_valid;
  slot_t            slot;
  slot_t            slot_next;
  logic [RW-1:0]    s2_row;
  logic [CW-1:0]    s2_col;
  logic [PIX_W-1:0] s2_pix;
  logic [PIX_W-1:0] s2_up;
  logic             s2_has_down;

  logic             fire;
  logic             is_last;
  logic             load;
  logic [PIX_W:0]   sum;

  assign fire    = result.valid && result.ready;
  assign is_last = (slot == SLOT_DOWN) || ((slot == SLOT_SELF) && !s2_has_down);
  assign free    = !s2_valid || (fire && is_last);
  assign load    = s1_valid && s1_plan.emit && free;

  // Rounded-up average of the stored line above and the sample below.
  assign sum = (PIX_W + 1)'(rd_data) + (PIX_W + 1)'(s1_pix) + (PIX_W + 1)'(1);

  // Next slot of the run.
  always_comb begin
    slot_next = slot;
    if (load) begin
      slot_next = s1_plan.has_up ? SLOT_UP : SLOT_SELF;
    end else if (fire) begin
      unique case (slot)
        SLOT_UP:   slot_next = SLOT_SELF;
        SLOT_SELF: slot_next = SLOT_DOWN;
        default:   slot_next = slot;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      slot     <= SLOT_SELF;
    end else begin
      slot <= slot_next;
      if (load) begin
        s2_valid <= 1'b1;
      end else if (fire && is_last) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_row      <= s1_row;
      s2_col      <= s1_col;
      s2_pix      <= s1_pix;
      s2_up       <= s1_plan.up_copy ? s1_pix : sum[PIX_W:1];
      s2_has_down <= s1_plan.has_down;
    end
  end

  // Result payload for the current slot.
  always_comb begin
    result.valid       = s2_valid;
    result.column      = POS_W'(s2_col);
    result.last_of_run = is_last;
    unique case (slot)
      SLOT_UP: begin
        result.row   = POS_W'(s2_row - RW'(1));
        result.value = s2_up;
      end
      SLOT_DOWN: begin
        result.row   = POS_W'(s2_row + RW'(1));
        result.value = s2_pix;
      end
      default: begin
        result.row   = POS_W'(s2_row);
        result.value = s2_pix;
      end
    endcase
  end

endmodule

### rtl/core/field_discard_line_average_deinterlace_core.sv
// The first result of a sample is offered once the sample has passed the read
// stage and been loaded into the result register.
// The result port carries one result per cycle while the receiver is ready: two
// results per sample on kept lines, three on the bottom edge line, one on the
// first line of a top-first frame and a spare line, and none on dropped lines.
// Reset clears counters and valids and presets field order, slot and registers.
// ---------------------------------------------------------------------------
// field_discard_line_average_deinterlace_core
// Field-discard deinterlacer rebuilding dropped lines by line averaging.
// ---------------------------------------------------------------------------
`include "field_discard_line_average_deinterlace_core_macros.svh"

module field_discard_line_average_deinterlace_core #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_LINES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_en,
  input  logic [fdlad_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [fdlad_pkg::CFG_W-1:0]     write_data,
  fdlad_in_if.sink                        sample,
  fdlad_out_if.source                     result
);
  import fdlad_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_LINES);

  logic             s1_valid;
  logic             s1_take;
  plan_t            s1_plan;
  logic [RW-1:0]    s1_row;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pix;
  logic             rd_en;
  logic [CW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;
  logic             wr_en;
  logic             free;

  // Front end: registers, counters and the read stage.
  fdlad_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .sample     (sample),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1_plan    (s1_plan),
    .s1_row     (s1_row),
    .s1_col     (s1_col),
    .s1_pix     (s1_pix),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  // A sample leaves the read stage when dropped or when the result stage frees.
  assign s1_take = s1_valid && (!s1_plan.emit || free);
  assign wr_en   = s1_take && s1_plan.wr;

  // Line store holding the previous kept line.
  fdlad_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Result stage.
  fdlad_emit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_plan  (s1_plan),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .s1_pix   (s1_pix),
    .rd_data  (rd_data),
    .result   (result),
    .free     (free)
  );

  // A store write never meets a read of the same column.
  `FDLAD_ASSERT_NOW(a_store_no_clash, clk, rst, wr_en && rd_en, s1_col != rd_addr, "store clash")
  // An accepted sample always occupies the read stage next.
  `FDLAD_ASSERT_NEXT(a_accept_fills, clk, rst, sample.valid && sample.ready, s1_valid, "request lost")
  // A sample held in the read stage keeps its column.
  `FDLAD_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s1_take, s1_valid && $stable(s1_col), "s1 lost")

endmodule

### tb/field_discard_line_average_deinterlace_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line-average deinterlacer core testbench
// Streams raster-order frames of both field orders through the core under
// several line sizes, including the clamped extremes. Every produced sample
// is checked against typed results or a behavioural model of the field discard
// and line averaging, with random back-pressure and gaps on both channels.
// ---------------------------------------------------------------------------
module field_discard_line_average_deinterlace_core_tb;
  import fdlad_pkg::*;

  localparam int MAX_WIDTH       = 4096;
  localparam int MAX_LINES       = 4096;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  // One produced sample, laid out as the result channel carries it.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [PIX_W-1:0] value;
    logic             last_of_run;
  } px_result_t;

  typedef enum logic [1:0] {
    STEP_SAMPLE,
    STEP_WIDTH,
    STEP_LINES
  } step_kind_t;

  // A directed request: a sample, or a register write before the next one.
  typedef struct packed {
    step_kind_t   kind;
    logic [12:0]  data;
    logic         tff;
    logic         typed;
    logic [1:0]   count;
    px_result_t   r0;
    px_result_t   r1;
    px_result_t   r2;
  } directed_step_t;

  localparam px_result_t NO_RESULT = '0;

  // Two-sample lines. The first two frames have four lines, one of each field
  // order; the third has five lines, so its last line passes straight through.
  localparam directed_step_t DIRECTED_STEPS [29] = '{
    '{STEP_WIDTH, 13'd0, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_LINES, 13'd0, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    // Top field first: even lines kept, bottom line copied from line two.
    '{STEP_SAMPLE, 13'h000, 1'b1, 1'b1, 2'd1,
      '{12'd0, 12'd0, 8'h00, 1'b1}, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0FF, 1'b0, 1'b1, 2'd1,
      '{12'd0, 12'd1, 8'hFF, 1'b1}, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h05A, 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0A5, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0FF, 1'b0, 1'b1, 2'd3,
      '{12'd1, 12'd0, 8'h80, 1'b0}, '{12'd2, 12'd0, 8'hFF, 1'b0},
      '{12'd3, 12'd0, 8'hFF, 1'b1}},
    '{STEP_SAMPLE, 13'h000, 1'b1, 1'b1, 2'd3,
      '{12'd1, 12'd1, 8'h80, 1'b0}, '{12'd2, 12'd1, 8'h00, 1'b0},
      '{12'd3, 12'd1, 8'h00, 1'b1}},
    '{STEP_SAMPLE, 13'h033, 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0CC, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    // Bottom field first: odd lines kept, top line copied from line one.
    '{STEP_SAMPLE, 13'h080, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h07F, 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h001, 1'b1, 1'b1, 2'd2,
      '{12'd0, 12'd0, 8'h01, 1'b0}, '{12'd1, 12'd0, 8'h01, 1'b1}, NO_RESULT},
    '{STEP_SAMPLE, 13'h0FE, 1'b0, 1'b1, 2'd2,
      '{12'd0, 12'd1, 8'hFE, 1'b0}, '{12'd1, 12'd1, 8'hFE, 1'b1}, NO_RESULT},
    '{STEP_SAMPLE, 13'h010, 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0EF, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h002, 1'b1, 1'b1, 2'd2,
      '{12'd2, 12'd0, 8'h02, 1'b0}, '{12'd3, 12'd0, 8'h02, 1'b1}, NO_RESULT},
    '{STEP_SAMPLE, 13'h0FF, 1'b0, 1'b1, 2'd2,
      '{12'd2, 12'd1, 8'hFF, 1'b0}, '{12'd3, 12'd1, 8'hFF, 1'b1}, NO_RESULT},
    // Odd line count: line four lies outside both fields.
    '{STEP_LINES, 13'd5, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h03C, 1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0C3, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h011, 1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h022, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h044, 1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h088, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h099, 1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0AA, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h000, 1'b1, 1'b1, 2'd1,
      '{12'd4, 12'd0, 8'h00, 1'b1}, NO_RESULT, NO_RESULT},
    '{STEP_SAMPLE, 13'h0FF, 1'b0, 1'b1, 2'd1,
      '{12'd4, 12'd1, 8'hFF, 1'b1}, NO_RESULT, NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 write_en;
  logic [REG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     write_data;

  // Model state: settings, raster position, latched field order, line store.
  logic [CFG_W-1:0] width_setting = CFG_W'(RESET_LINE_WIDTH);
  logic [CFG_W-1:0] lines_setting = CFG_W'(RESET_LINE_COUNT);
  int unsigned      col_pos       = 0;
  int unsigned      row_pos       = 0;
  logic             keep_top      = 1'b1;
  logic [7:0]       kept_line_model [MAX_WIDTH];

  px_result_t expected_results [$];

  int send_idle_pct = 14;
  int recv_idle_pct = 58;
  int error_count   = 0;
  int n_samples     = 0;
  int n_results     = 0;
  int n_writes      = 0;

  logic [3:0] hold_off_seq  = '0;
  logic [3:0] hold_off_seen = '0;
  int         hold_left     = 0;

  fdlad_in_if  sample_if ();
  fdlad_out_if result_if ();

  field_discard_line_average_deinterlace_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_LINES(MAX_LINES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .write_en  (write_en),
    .reg_index (reg_index),
    .write_data(write_data),
    .sample    (sample_if),
    .result    (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted result, then choose the next ready.
  always @(posedge clk) begin : result_check
    px_result_t got;
    px_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = '{result_if.row, result_if.column, result_if.value, result_if.last_of_run};
      n_results++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                 $time, got.row, got.column, got.value, got.last_of_run);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b (row/col/value/last)",
                   $time, want.row, want.column, want.value, want.last_of_run,
                   got.row, got.column, got.value, got.last_of_run);
        end
      end
    end
    if (hold_off_seen != hold_off_seq) begin
      hold_off_seen    <= hold_off_seq;
      hold_left        <= HOLD_OFF_CYCLES;
      result_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic int unsigned clamp_setting(input logic [CFG_W-1:0] v, input int lo,
                                                input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Deinterlacer behaviour for one sample: the results it produces, in order.
  function automatic void predict_sample(input logic [7:0] pix, input logic tff,
                                         output px_result_t res [3], output int count);
    int unsigned width;
    int unsigned lines;
    int unsigned even_lines;
    int unsigned r;
    int unsigned c;
    logic [8:0]  avg;
    logic        keep;
    width      = clamp_setting(width_setting, WIDTH_MIN, MAX_WIDTH);
    lines      = clamp_setting(lines_setting, LINES_MIN, MAX_LINES);
    even_lines = lines & ~32'd1;
    r          = row_pos;
    c          = col_pos;
    count      = 0;
    res[0]     = '0;
    res[1]     = '0;
    res[2]     = '0;

    if (r == 0 && c == 0) keep_top = tff;
    avg = ({1'b0, kept_line_model[c]} + {1'b0, pix} + 9'd1) >> 1;

    if (r >= even_lines) begin
      // Spare line of an odd-sized frame passes through.
      res[count] = '{12'(r), 12'(c), pix, 1'b0};
      count++;
    end else begin
      keep = keep_top ? (r[0] == 1'b0) : (r[0] == 1'b1);
      if (keep) begin
        if (keep_top) begin
          if (r >= 2) begin
            res[count] = '{12'(r - 1), 12'(c), avg[7:0], 1'b0};
            count++;
          end
          res[count] = '{12'(r), 12'(c), pix, 1'b0};
          count++;
          // The bottom line has no kept line below it and copies this one.
          if (r + 2 == even_lines) begin
            res[count] = '{12'(r + 1), 12'(c), pix, 1'b0};
            count++;
          end
        end else begin
          // The top line has no kept line above it and copies line one.
          res[count] = '{12'(r - 1), 12'(c), (r == 1) ? pix : avg[7:0], 1'b0};
          count++;
          res[count] = '{12'(r), 12'(c), pix, 1'b0};
          count++;
        end
        kept_line_model[c] = pix;
      end
    end
    if (count > 0) res[count - 1].last_of_run = 1'b1;

    c++;
    if (c >= width) begin
      c = 0;
      r++;
      if (r >= lines) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // Offer one sample, with a random gap first, and wait for its acceptance.
  task automatic offer_sample(input logic [7:0] pix, input logic tff);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    sample_if.valid           <= 1'b1;
    sample_if.pixel           <= pix;
    sample_if.top_field_first <= tff;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    n_samples++;
  endtask

  task automatic feed_sample(input logic [7:0] pix, input logic tff);
    px_result_t predicted [3];
    int         n_predicted;
    predict_sample(pix, tff, predicted, n_predicted);
    for (int k = 0; k < n_predicted; k++) expected_results.push_back(predicted[k]);
    offer_sample(pix, tff);
  endtask

  // Registers change only once every result is out and the core has settled.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    sample_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= val;
    @(posedge clk);
    write_en <= 1'b0;
    if (idx == REG_LINE_WIDTH) width_setting = val;
    else lines_setting = val;
    n_writes++;
  endtask

  // Set both sizes, then stream whole frames of random samples.
  task automatic run_phase(input logic [CFG_W-1:0] width_val, input logic [CFG_W-1:0] lines_val,
                           input int frames, input int pause_at, input bit hold_off);
    int total;
    write_register(REG_LINE_WIDTH, width_val);
    write_register(REG_LINE_COUNT, lines_val);
    total = frames * clamp_setting(width_setting, WIDTH_MIN, MAX_WIDTH)
                   * clamp_setting(lines_setting, LINES_MIN, MAX_LINES);
    if (hold_off) hold_off_seq <= hold_off_seq + 1'b1;
    for (int k = 0; k < total; k++) begin
      if (k == pause_at) begin
        // Let the core drain completely in the middle of a frame.
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      feed_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Start a frame at one size, then shrink the sizes so the frame ends early;
  // the tail count brings the raster back to the start of a frame.
  task automatic run_cut_frame(input logic [CFG_W-1:0] width_val,
                               input logic [CFG_W-1:0] lines_val, input int head,
                               input logic [CFG_W-1:0] width_cut,
                               input logic [CFG_W-1:0] lines_cut, input int tail);
    write_register(REG_LINE_WIDTH, width_val);
    write_register(REG_LINE_COUNT, lines_val);
    for (int k = 0; k < head; k++) begin
      feed_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    write_register(REG_LINE_WIDTH, width_cut);
    write_register(REG_LINE_COUNT, lines_cut);
    for (int k = 0; k < tail; k++) begin
      feed_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random_phases(input int pause_at);
    int w;
    int l;
    int frames;
    for (int p = 0; p < 3; p++) begin
      w      = $urandom_range(1, 6);
      l      = $urandom_range(3, 6);
      frames = 1 + 16 / (clamp_setting(CFG_W'(w), WIDTH_MIN, MAX_WIDTH)
                         * clamp_setting(CFG_W'(l), LINES_MIN, MAX_LINES));
      run_phase(CFG_W'(w), CFG_W'(l), frames, (p == 0) ? pause_at : -1, 1'b0);
    end
  endtask

  initial begin : stimulus
    directed_step_t dir_step;
    px_result_t     typed_set [3];
    px_result_t     scratch [3];
    int             n_scratch;
    rst                       = 1'b1;
    write_en                  = 1'b0;
    reg_index                 = '0;
    write_data                = '0;
    sample_if.valid           = 1'b0;
    sample_if.pixel           = '0;
    sample_if.top_field_first = 1'b0;
    result_if.ready           = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests, with light sender gaps and heavy receiver stalls.
    for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
      dir_step = DIRECTED_STEPS[i];
      unique case (dir_step.kind)
        STEP_WIDTH: begin
          write_register(REG_LINE_WIDTH, dir_step.data);
        end
        STEP_LINES: begin
          write_register(REG_LINE_COUNT, dir_step.data);
        end
        default: begin
          if (dir_step.typed) begin
            predict_sample(dir_step.data[7:0], dir_step.tff, scratch, n_scratch);
            typed_set[0] = dir_step.r0;
            typed_set[1] = dir_step.r1;
            typed_set[2] = dir_step.r2;
            for (int k = 0; k < dir_step.count; k++) expected_results.push_back(typed_set[k]);
            offer_sample(dir_step.data[7:0], dir_step.tff);
          end else begin
            feed_sample(dir_step.data[7:0], dir_step.tff);
          end
        end
      endcase
    end

    run_random_phases(-1);
    // Widest line: the width register above its limit for the first ten
    // samples of a line, then lowered so that the line ends at once.
    run_cut_frame(13'h1FFF, 13'd3, 10, 13'd2, 13'd4, 7);

    // Heavy sender gaps, light receiver stalls.
    send_idle_pct = 58;
    recv_idle_pct = 14;
    run_random_phases(17);
    // Tallest frame: the count register at all ones for eight lines, then
    // lowered so that the current line passes through and the frame ends.
    run_cut_frame(13'd1, 13'h1FFF, 16, 13'd2, 13'd4, 2);

    // No idling; the receiver first holds off long enough to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(13'd8, 13'd6, 2, -1, 1'b1);
    run_random_phases(-1);

    sample_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Streamed %0d samples and checked %0d results across %0d register writes,",
             n_samples, n_results, n_writes);
    $display("covering both field orders, odd and even line counts and the size limits.");
    if (error_count == 0) begin
      $display("field_discard_line_average_deinterlace_core_tb: PASS");
    end else begin
      $display("field_discard_line_average_deinterlace_core_tb: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(1_000_000);
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("field_discard_line_average_deinterlace_core_tb: FAIL");
    $finish;
  end

endmodule
